// File: hw/rtl/frustum_cull_test_macros.svh
// Assertion macros for the frustum cull test block.
// Used by the port checker; depends on nothing else.
`ifndef FRUSTUM_CULL_TEST_MACROS_SVH
`define FRUSTUM_CULL_TEST_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define FCT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define FCT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/fcull_pkg.sv
// Shared types and constants for the frustum cull test block.
// No dependencies; imported by every module of the block.
package fcull_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int COEF_WIDTH     = 16;
   localparam int FRAC_BITS      = 14;
   localparam int PLANE_COUNT    = 6;
   localparam int AXIS_COUNT     = 3;
   localparam int RAD_WIDTH      = COORD_WIDTH - 1;
   localparam int PROD_WIDTH     = COORD_WIDTH + COEF_WIDTH;
   localparam int OFFS_WIDTH     = COEF_WIDTH + FRAC_BITS;
   // three products plus the scaled offset, with headroom for the sum
   localparam int DIST_WIDTH     = ((PROD_WIDTH > OFFS_WIDTH) ? PROD_WIDTH : OFFS_WIDTH) + 2;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_IDX_WIDTH  = $clog2(PLANE_COUNT);
   localparam int CSR_ADDR_WIDTH = CSR_IDX_WIDTH + 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [RAD_WIDTH-1:0]          radius_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [DIST_WIDTH-1:0]  dist_type;
   typedef logic [CSR_DATA_WIDTH-1:0]     csr_word_type;
   typedef logic [CSR_ADDR_WIDTH-1:0]     csr_addr_type;

   typedef enum logic [1:0] {
      ACT_POINT  = 2'd0,
      ACT_SPHERE = 2'd1,
      ACT_BOX    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      VERDICT_OUT   = 2'd0,
      VERDICT_IN    = 2'd1,
      VERDICT_CROSS = 2'd2
   } verdict_type;

   // register layout: d in the top quarter, a in the bottom
   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] d;
      logic signed [COEF_WIDTH-1:0] c;
      logic signed [COEF_WIDTH-1:0] b;
      logic signed [COEF_WIDTH-1:0] a;
   } plane_type;

   // per-plane test results handed to the verdict stage
   typedef struct packed {
      logic pt_out;     // centre behind the plane
      logic sph_out;    // centre further behind than the radius
      logic sph_cross;  // centre closer to the plane than the radius
      logic box_none;   // no box corner on the inner side
      logic box_all;    // every box corner on the inner side
   } plane_flags_type;

endpackage

// File: hw/rtl/fcull_csr.sv
// APB-style register file holding the six frustum planes.
// Depends on fcull_pkg.
module fcull_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  fcull_pkg::csr_addr_type  paddr,
   input  fcull_pkg::csr_word_type  pwdata,
   output fcull_pkg::csr_word_type  prdata,
   output logic                     pready,
   output fcull_pkg::plane_type     planes [fcull_pkg::PLANE_COUNT]
);
   import fcull_pkg::*;

   csr_word_type               plane_ff [PLANE_COUNT];
   logic [CSR_IDX_WIDTH-1:0]   reg_idx;
   logic                       idx_ok;
   logic                       wr_en;

   // 64-bit registers at 8-byte steps
   assign reg_idx = paddr[CSR_ADDR_WIDTH-1:3];
   assign idx_ok  = (reg_idx < CSR_IDX_WIDTH'(PLANE_COUNT));
   assign wr_en   = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (wr_en && idx_ok) begin
         plane_ff[reg_idx] <= pwdata;
      end
   end

   // read back, zero beyond the list
   assign prdata = idx_ok ? plane_ff[reg_idx] : '0;

   always_comb begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
         planes[i] = plane_type'(plane_ff[i]);
      end
   end

endmodule

// File: hw/rtl/fcull_plane.sv
// Distance pipeline for one plane: products, corner selection, sums, compares.
// Depends on fcull_pkg. Four register stages, no stall.
module fcull_plane (
   input  logic                         clock,
   input  fcull_pkg::plane_type         plane,
   input  fcull_pkg::coord_type         lo [fcull_pkg::AXIS_COUNT],
   input  fcull_pkg::coord_type         hi [fcull_pkg::AXIS_COUNT],
   input  fcull_pkg::dist_type          rs_s3,
   output fcull_pkg::plane_flags_type   flags
);
   import fcull_pkg::*;

   prod_type        coef [AXIS_COUNT];
   prod_type        prod_lo_in [AXIS_COUNT];
   prod_type        prod_hi_in [AXIS_COUNT];
   prod_type        prod_lo_ff [AXIS_COUNT];
   prod_type        prod_hi_ff [AXIS_COUNT];
   prod_type        sel_lo_ff  [AXIS_COUNT];
   prod_type        sel_max_ff [AXIS_COUNT];
   prod_type        sel_min_ff [AXIS_COUNT];
   dist_type        offs;
   dist_type        dlo_in, dmax_in, dmin_in;
   dist_type        dlo_ff, dmax_ff, dmin_ff;
   dist_type        neg_rs;
   plane_flags_type flags_in, flags_ff;

   assign coef[0] = PROD_WIDTH'(plane.a);
   assign coef[1] = PROD_WIDTH'(plane.b);
   assign coef[2] = PROD_WIDTH'(plane.c);

   // stage 1: one product per axis and bound
   always_comb begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
         prod_lo_in[i] = coef[i] * PROD_WIDTH'(lo[i]);
         prod_hi_in[i] = coef[i] * PROD_WIDTH'(hi[i]);
      end
   end

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
   end

   // stage 2: per axis, larger and smaller term gives the extreme corners
   always_ff @(posedge clock) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
         sel_lo_ff[i] <= prod_lo_ff[i];
         if (prod_lo_ff[i] > prod_hi_ff[i]) begin
            sel_max_ff[i] <= prod_lo_ff[i];
            sel_min_ff[i] <= prod_hi_ff[i];
         end else begin
            sel_max_ff[i] <= prod_hi_ff[i];
            sel_min_ff[i] <= prod_lo_ff[i];
         end
      end
   end

   // stage 3: signed distances in 2^-14 units
   assign offs = DIST_WIDTH'(plane.d) <<< FRAC_BITS;

   assign dlo_in  = DIST_WIDTH'(sel_lo_ff[0]) + DIST_WIDTH'(sel_lo_ff[1])
                  + DIST_WIDTH'(sel_lo_ff[2]) + offs;
   assign dmax_in = DIST_WIDTH'(sel_max_ff[0]) + DIST_WIDTH'(sel_max_ff[1])
                  + DIST_WIDTH'(sel_max_ff[2]) + offs;
   assign dmin_in = DIST_WIDTH'(sel_min_ff[0]) + DIST_WIDTH'(sel_min_ff[1])
                  + DIST_WIDTH'(sel_min_ff[2]) + offs;

   always_ff @(posedge clock) begin
      dlo_ff  <= dlo_in;
      dmax_ff <= dmax_in;
      dmin_ff <= dmin_in;
   end

   // stage 4: sign and radius compares
   assign neg_rs = -rs_s3;

   always_comb begin
      flags_in.pt_out    = (dlo_ff < 0);
      flags_in.sph_out   = (dlo_ff < neg_rs);
      flags_in.sph_cross = (dlo_ff < rs_s3) && (dlo_ff > neg_rs);
      flags_in.box_none  = (dmax_ff < 0);
      flags_in.box_all   = (dmin_ff >= 0);
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   assign flags = flags_ff;

endmodule

// File: hw/rtl/frustum_cull_test.sv
// One result per accepted word; rsp_valid follows the plane stages and the output register.
// Throughput: one word per cycle, busy held low; four plane stages plus the output register.
// Six plane units each run product, corner select, sum and compare stages in parallel.
// Reset (synchronous, active high) clears the valid bits and the plane registers.
// Results are shown for one cycle; the receiver cannot stall.
// Depends on fcull_pkg, fcull_csr and fcull_plane.
module frustum_cull_test (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_action,
   input  fcull_pkg::coord_type     req_first_x,
   input  fcull_pkg::coord_type     req_first_y,
   input  fcull_pkg::coord_type     req_first_z,
   input  fcull_pkg::coord_type     req_second_x,
   input  fcull_pkg::coord_type     req_second_y,
   input  fcull_pkg::coord_type     req_second_z,
   input  fcull_pkg::radius_type    req_radius,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_verdict,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  fcull_pkg::csr_addr_type  paddr,
   input  fcull_pkg::csr_word_type  pwdata,
   output fcull_pkg::csr_word_type  prdata,
   output logic                     pready
);
   import fcull_pkg::*;

   localparam int STAGES = 4;

   plane_type       planes [PLANE_COUNT];
   plane_flags_type flags  [PLANE_COUNT];
   coord_type       lo [AXIS_COUNT];
   coord_type       hi [AXIS_COUNT];
   logic            accept;
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [1:0]      act_ff [STAGES];
   radius_type      rad_s1_ff, rad_s2_ff;
   dist_type        rs_s3_ff;
   logic            any_pt_out, any_sph_out, any_sph_cross, any_box_none, all_box_all;
   verdict_type     verdict_in;
   logic            rsp_valid_ff;
   verdict_type     rsp_verdict_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign lo[0] = req_first_x;
   assign lo[1] = req_first_y;
   assign lo[2] = req_first_z;
   assign hi[0] = req_second_x;
   assign hi[1] = req_second_y;
   assign hi[2] = req_second_z;

   fcull_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .planes  (planes)
   );

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fcull_plane u_plane (
         .clock (clock),
         .plane (planes[p]),
         .lo    (lo),
         .hi    (hi),
         .rs_s3 (rs_s3_ff),
         .flags (flags[p])
      );
   end

   // valid bits follow the word through the plane stages
   assign valid_in = {valid_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // side data: action to the verdict stage, scaled radius for stage 4
   always_ff @(posedge clock) begin
      act_ff[0] <= req_action;
      for (int s = 1; s < STAGES; s++) begin
         act_ff[s] <= act_ff[s-1];
      end
      rad_s1_ff <= req_radius;
      rad_s2_ff <= rad_s1_ff;
      rs_s3_ff  <= DIST_WIDTH'(rad_s2_ff) <<< FRAC_BITS;
   end

   // reduce the six planes
   always_comb begin
      any_pt_out    = 1'b0;
      any_sph_out   = 1'b0;
      any_sph_cross = 1'b0;
      any_box_none  = 1'b0;
      all_box_all   = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         any_pt_out    = any_pt_out    | flags[p].pt_out;
         any_sph_out   = any_sph_out   | flags[p].sph_out;
         any_sph_cross = any_sph_cross | flags[p].sph_cross;
         any_box_none  = any_box_none  | flags[p].box_none;
         all_box_all   = all_box_all   & flags[p].box_all;
      end
   end

   // verdict per test kind; the unused code reads as outside
   always_comb begin
      unique case (act_ff[STAGES-1])
         ACT_POINT: begin
            verdict_in = any_pt_out ? VERDICT_OUT : VERDICT_IN;
         end
         ACT_SPHERE: begin
            if (any_sph_out) begin
               verdict_in = VERDICT_OUT;
            end else if (any_sph_cross) begin
               verdict_in = VERDICT_CROSS;
            end else begin
               verdict_in = VERDICT_IN;
            end
         end
         ACT_BOX: begin
            if (any_box_none) begin
               verdict_in = VERDICT_OUT;
            end else if (all_box_all) begin
               verdict_in = VERDICT_IN;
            end else begin
               verdict_in = VERDICT_CROSS;
            end
         end
         default: begin
            verdict_in = VERDICT_OUT;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[STAGES-1];
      end
      rsp_verdict_ff <= verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

// File: hw/rtl/fcull_checker.sv
// Port-level checker for frustum_cull_test, bound to the top level.
// Depends on fcull_pkg and frustum_cull_test_macros.svh.
`include "frustum_cull_test_macros.svh"

module fcull_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [1:0]               req_action,
   input  logic                     rsp_valid,
   input  logic [1:0]               rsp_verdict
);
   import fcull_pkg::*;

   // pipeline never refuses a word
   `FCT_ASSERT_ALWAYS(a_never_busy, clock, !busy, "busy raised")

   // every accepted word gives its strobe after the plane stages and the output register
   `FCT_ASSERT(a_word_out, clock, reset, (start && !busy) |-> ##5 rsp_valid, "result lost")

   // no strobe without an accepted word that it belongs to
   `FCT_ASSERT(a_no_extra, clock, reset, rsp_valid |-> $past(start && !busy, 5), "spurious result")

   // a point test is never crossing
   `FCT_ASSERT(a_point_verdict, clock, reset, (start && !busy && req_action == ACT_POINT) |-> ##5 (rsp_verdict == VERDICT_OUT || rsp_verdict == VERDICT_IN), "point gave crossing")

endmodule

bind frustum_cull_test fcull_checker u_fcull_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_action  (req_action),
   .rsp_valid   (rsp_valid),
   .rsp_verdict (rsp_verdict)
);
